// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file qll_checker.sv.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define QLL_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("qll: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define QLL_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("qll: next-cycle check failed");

`endif

// ===== hdl/qll_pkg.sv =====
// Shared types and constants for the quantized linear layer.
// No dependencies; imported by every module of the block but qll_mem.
package qll_pkg;

	localparam int DEF_MAX_IN  = 256;
	localparam int DEF_MAX_OUT = 64;

	localparam int DEF_IN_LEN  = 256;
	localparam int DEF_OUT_LEN = 64;
	localparam logic [31:0] DEF_MULT = 32'h0100_0000;   // 1.0 in Q8.24

	localparam int ZERO_POINT = 128;
	localparam int SAT_HI     = 127;
	localparam int SAT_LO     = -128;
	localparam int FRAC_BITS  = 24;
	localparam int RND_HALF   = 1 << (FRAC_BITS - 1);

	localparam int PADDR_W = 5;

	typedef enum logic [1:0] {
		FUNC_WEIGHT = 2'd0,
		FUNC_BIAS   = 2'd1,
		FUNC_ACT    = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		REG_IN_LEN       = 3'd0,
		REG_OUT_LEN      = 3'd1,
		REG_ACC_MULT     = 3'd2,
		REG_BIAS_MULT    = 3'd3,
		REG_OUT_UNSIGNED = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BIAS,
		OP_MAC,
		OP_FIN
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_FIN,
		ST_DRAIN
	} st_t;

	typedef struct packed {
		logic [8:0]  in_len;
		logic [6:0]  out_len;
		logic [31:0] acc_mult;
		logic [31:0] bias_mult;
		logic        out_unsigned;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] channel;
		logic       last;
	} issue_t;

	typedef struct packed {
		logic strobe;
		logic last;
	} dp_stat_t;

endpackage

// ===== hdl/qll_mem.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies; holds the weight store and the activation/bias store.
module qll_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/qll_ctrl.sv =====
// Sequencer: store writes, activation count, and the per-channel read schedule.
// Depends on qll_pkg.
module qll_ctrl #(
	parameter int MAX_IN  = qll_pkg::DEF_MAX_IN,
	parameter int MAX_OUT = qll_pkg::DEF_MAX_OUT,
	localparam int RW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
	localparam int CW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1,
	localparam int VW = $clog2(MAX_IN + MAX_OUT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         func,
	input  logic [7:0]         row_index,
	input  logic [5:0]         col_index,
	input  qll_pkg::cfg_t      cfg,
	input  logic               count_clr,
	input  qll_pkg::dp_stat_t  stat,
	output logic               busy,
	output qll_pkg::issue_t    issue,
	output logic               w_we,
	output logic [RW+CW-1:0]   w_waddr,
	output logic [RW+CW-1:0]   w_raddr,
	output logic               v_we,
	output logic [VW-1:0]      v_waddr,
	output logic [VW-1:0]      v_raddr
);

	import qll_pkg::*;

	st_t        state_q, state_d;
	logic [8:0] count_q;
	logic [8:0] k_q;
	logic [6:0] n_q;
	logic       accept;
	logic       vec_done;
	logic       k_last;
	logic       n_last;
	logic       row_ok;
	logic       col_ok;

	assign accept   = start && (state_q == ST_IDLE);
	assign vec_done = (count_q == cfg.in_len - 9'd1);
	assign k_last   = (k_q == cfg.in_len - 9'd1);
	assign n_last   = (n_q == cfg.out_len - 7'd1);
	assign row_ok   = int'(row_index) < MAX_IN;
	assign col_ok   = int'(col_index) < MAX_OUT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_ACT && vec_done) begin
					state_d = ST_BIAS;
				end
			end
			ST_BIAS:  state_d = ST_MAC;
			ST_MAC: begin
				if (k_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:   state_d = n_last ? ST_DRAIN : ST_BIAS;
			ST_DRAIN: begin
				if (stat.strobe && stat.last) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = (state_q != ST_IDLE);
		issue.op      = OP_NONE;
		issue.channel = n_q[5:0];
		issue.last    = n_last;
		w_raddr       = {RW'(k_q), CW'(n_q)};
		v_raddr       = VW'(k_q);
		w_we          = 1'b0;
		w_waddr       = {RW'(row_index), CW'(col_index)};
		v_we          = 1'b0;
		v_waddr       = VW'(count_q);
		unique case (state_q)
			ST_BIAS: begin
				issue.op = OP_BIAS;
				v_raddr  = VW'(MAX_IN) + VW'(n_q);
			end
			ST_MAC:  issue.op = OP_MAC;
			ST_FIN:  issue.op = OP_FIN;
			default: issue.op = OP_NONE;
		endcase
		if (accept) begin
			unique case (func)
				FUNC_WEIGHT: w_we = row_ok && col_ok;
				FUNC_BIAS: begin
					v_we    = col_ok;
					v_waddr = VW'(MAX_IN) + VW'(col_index);
				end
				FUNC_ACT:    v_we = 1'b1;
				default:     v_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (count_clr) begin
				count_q <= '0;
			end else if (accept && func == FUNC_ACT) begin
				count_q <= vec_done ? 9'd0 : count_q + 9'd1;
			end
			if (state_q == ST_BIAS) begin
				k_q <= '0;
			end else if (state_q == ST_MAC && !k_last) begin
				k_q <= k_q + 9'd1;
			end
			if (state_q == ST_IDLE) begin
				n_q <= '0;
			end else if (state_q == ST_FIN) begin
				n_q <= n_q + 7'd1;
			end
		end
	end

endmodule

// ===== hdl/qll_dp.sv =====
// Datapath: byte MAC, shared scale multiplier, rounding, saturation, result word.
// Depends on qll_pkg; fed by qll_ctrl and the two store RAMs.
module qll_dp #(
	parameter int MAX_IN = qll_pkg::DEF_MAX_IN,
	localparam int RW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
	localparam int DW = 16 + RW,
	localparam int TW = DW + 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qll_pkg::cfg_t     cfg,
	input  qll_pkg::issue_t   issue,
	input  logic [7:0]        v_rdata,
	input  logic [7:0]        w_rdata,
	output qll_pkg::dp_stat_t stat,
	output logic [5:0]        channel,
	output logic [7:0]        out_value
);

	import qll_pkg::*;

	op_t                  op_s1, op_s2, op_s3;
	logic [5:0]           ch_s1, ch_s2, ch_s3;
	logic                 last_s1, last_s2, last_s3;
	logic signed [8:0]    xs;
	logic signed [8:0]    ws;
	logic signed [17:0]   pm;
	logic signed [DW-1:0] mul_a;
	logic signed [32:0]   mul_b;
	logic signed [DW+32:0] mul_q;
	logic signed [DW-1:0] dot_q;
	logic signed [TW-1:0] total_q;
	logic signed [TW-1:0] rnd_c;
	logic [7:0]           sat_c;
	logic                 strobe_q;
	logic                 last_q;

	// vector RAM word is the bias on a BIAS op, the activation on a MAC op
	assign xs = 9'(signed'({1'b0, v_rdata}) - ZERO_POINT);
	assign ws = 9'(signed'({1'b0, w_rdata}) - ZERO_POINT);
	assign pm = xs * ws;

	always_comb begin
		if (op_s1 == OP_FIN) begin
			mul_a = dot_q;
			mul_b = signed'({1'b0, cfg.acc_mult});
		end else begin
			mul_a = DW'(xs);
			mul_b = signed'({1'b0, cfg.bias_mult});
		end
	end

	// floor((total + half) / 2^24), then clamp to a signed byte
	always_comb begin
		rnd_c = (total_q + TW'(RND_HALF)) >>> FRAC_BITS;
		if (rnd_c > TW'(SAT_HI)) begin
			sat_c = 8'(SAT_HI);
		end else if (rnd_c < TW'(SAT_LO)) begin
			sat_c = 8'(SAT_LO);
		end else begin
			sat_c = rnd_c[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1    <= OP_NONE;
			op_s2    <= OP_NONE;
			op_s3    <= OP_NONE;
			strobe_q <= 1'b0;
		end else begin
			op_s1    <= issue.op;
			op_s2    <= op_s1;
			op_s3    <= op_s2;
			strobe_q <= (op_s3 == OP_FIN);
		end
	end

	always_ff @(posedge clk) begin
		ch_s1   <= issue.channel;
		ch_s2   <= ch_s1;
		ch_s3   <= ch_s2;
		last_s1 <= issue.last;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		if (op_s1 == OP_BIAS || op_s1 == OP_FIN) begin
			mul_q <= mul_a * mul_b;
		end
		if (op_s1 == OP_BIAS) begin
			dot_q <= '0;
		end else if (op_s1 == OP_MAC) begin
			dot_q <= dot_q + DW'(pm);
		end
		if (op_s2 == OP_BIAS) begin
			total_q <= TW'(mul_q);
		end else if (op_s2 == OP_FIN) begin
			total_q <= total_q + TW'(mul_q);
		end
		if (op_s3 == OP_FIN) begin
			channel   <= ch_s3;
			last_q    <= last_s3;
			out_value <= cfg.out_unsigned ? sat_c + 8'(ZERO_POINT) : sat_c;
		end
	end

	assign stat.strobe = strobe_q;
	assign stat.last   = last_q;

endmodule

// ===== hdl/quantized_linear_layer_top.sv =====
// Top level of the quantized linear layer: APB register file, stores, sequencer,
// datapath. Depends on qll_pkg, qll_mem, qll_ctrl, qll_dp.
//
//  port group      kind        moves one word when
//  start/func..    command     start && !busy at a rising edge
//  result_strobe.. result      result_strobe high (one cycle, cannot be held off)
//  psel/penable..  APB         psel && penable && pwrite (pready tied high)
//
// Weight, bias and non-final activation words are taken without raising busy.
// The activation that completes a vector holds busy until the last channel's result
// is out: one MAC per cycle, bounded by the single read port of the weight RAM,
// plus a bias read and a scale step per channel.
// Reset clears control state only; stores hold garbage until written.
module quantized_linear_layer_top #(
	parameter int MAX_IN  = qll_pkg::DEF_MAX_IN,
	parameter int MAX_OUT = qll_pkg::DEF_MAX_OUT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  row_index,
	input  logic [5:0]  col_index,
	input  logic [7:0]  value,
	output logic        result_strobe,
	output logic [5:0]  channel,
	output logic [7:0]  out_value,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [qll_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import qll_pkg::*;

	localparam int RW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
	localparam int CW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int VW = $clog2(MAX_IN + MAX_OUT);
	localparam int INF_RST  = (DEF_IN_LEN > MAX_IN) ? MAX_IN : DEF_IN_LEN;
	localparam int OUTF_RST = (DEF_OUT_LEN > MAX_OUT) ? MAX_OUT : DEF_OUT_LEN;

	cfg_t        cfg_q;
	reg_idx_t    idx;
	logic        wr;
	logic [8:0]  inf_c;
	logic [6:0]  outf_c;
	issue_t      issue;
	dp_stat_t    stat;
	logic        w_we, v_we;
	logic [RW+CW-1:0] w_waddr, w_raddr;
	logic [VW-1:0]    v_waddr, v_raddr;
	logic [7:0]  w_rdata, v_rdata;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// lengths are clamped to 1..max when written
	always_comb begin
		if (pwdata[8:0] == 9'd0) begin
			inf_c = 9'd1;
		end else if (int'(pwdata[8:0]) > MAX_IN) begin
			inf_c = 9'(MAX_IN);
		end else begin
			inf_c = pwdata[8:0];
		end
		if (pwdata[6:0] == 7'd0) begin
			outf_c = 7'd1;
		end else if (int'(pwdata[6:0]) > MAX_OUT) begin
			outf_c = 7'(MAX_OUT);
		end else begin
			outf_c = pwdata[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_len       <= 9'(INF_RST);
			cfg_q.out_len      <= 7'(OUTF_RST);
			cfg_q.acc_mult     <= DEF_MULT;
			cfg_q.bias_mult    <= DEF_MULT;
			cfg_q.out_unsigned <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_IN_LEN:       cfg_q.in_len       <= inf_c;
				REG_OUT_LEN:      cfg_q.out_len      <= outf_c;
				REG_ACC_MULT:     cfg_q.acc_mult     <= pwdata;
				REG_BIAS_MULT:    cfg_q.bias_mult    <= pwdata;
				REG_OUT_UNSIGNED: cfg_q.out_unsigned <= pwdata[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_IN_LEN:       prdata = {23'b0, cfg_q.in_len};
			REG_OUT_LEN:      prdata = {25'b0, cfg_q.out_len};
			REG_ACC_MULT:     prdata = cfg_q.acc_mult;
			REG_BIAS_MULT:    prdata = cfg_q.bias_mult;
			REG_OUT_UNSIGNED: prdata = {31'b0, cfg_q.out_unsigned};
			default:          prdata = '0;
		endcase
	end

	qll_ctrl #(
		.MAX_IN  (MAX_IN),
		.MAX_OUT (MAX_OUT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.row_index (row_index),
		.col_index (col_index),
		.cfg       (cfg_q),
		.count_clr (wr && idx == REG_IN_LEN),
		.stat      (stat),
		.busy      (busy),
		.issue     (issue),
		.w_we      (w_we),
		.w_waddr   (w_waddr),
		.w_raddr   (w_raddr),
		.v_we      (v_we),
		.v_waddr   (v_waddr),
		.v_raddr   (v_raddr)
	);

	// weight RAM: row-major, channel in the low address bits
	qll_mem #(
		.DEPTH (2 ** (RW + CW)),
		.WIDTH (8)
	) u_wmem (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// activations at 0..MAX_IN-1, biases above them
	qll_mem #(
		.DEPTH (MAX_IN + MAX_OUT),
		.WIDTH (8)
	) u_vmem (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (value),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	qll_dp #(
		.MAX_IN (MAX_IN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.issue     (issue),
		.v_rdata   (v_rdata),
		.w_rdata   (w_rdata),
		.stat      (stat),
		.channel   (channel),
		.out_value (out_value)
	);

	assign result_strobe = stat.strobe;
	assign last          = stat.last;

endmodule

// ===== hdl/qll_checker.sv =====
// Port-level checks on the quantized linear layer, bound to the top level.
// Depends on qll_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qll_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       result_strobe,
	input logic       last
);

	import qll_pkg::*;

	// results only appear inside a busy window
	`QLL_ASSERT_IMPL(a_strobe_busy, clk, arst_n, result_strobe, busy)
	// the closing word of a vector ends the busy window
	`QLL_ASSERT_NEXT(a_last_idle, clk, arst_n, result_strobe && last, !busy)
	// store writes never start a computation
	`QLL_ASSERT_NEXT(a_write_idle, clk, arst_n, start && !busy && (func != FUNC_ACT), !busy)
	// busy only rises after an accepted activation
	`QLL_ASSERT_IMPL(a_busy_cause, clk, arst_n, $rose(busy), $past(start) && ($past(func) == FUNC_ACT))

endmodule

bind quantized_linear_layer_top qll_checker u_qll_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for quantized_linear_layer_top: APB setup, weight, bias and
// activation words, per-channel checks against an in-bench mirror of the layer.
// Depends on qll_pkg and the RTL of the block only.
module testbench;
	import qll_pkg::*;

	localparam int          RAND_ITEMS  = 130;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          LOAD_ROWS   = 6;
	localparam int          LOAD_COLS   = 16;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [5:0] channel;
		logic [7:0] out_value;
		logic       last;
	} fc_result_t;

	// Mirror of the layer: stores, registers and the results still due.
	class linear_layer_mirror;
		byte unsigned weight_mem [DEF_MAX_IN][DEF_MAX_OUT];
		byte unsigned bias_mem [DEF_MAX_OUT];
		byte unsigned act_mem [DEF_MAX_IN];
		int unsigned  act_count;
		int unsigned  n_in;
		int unsigned  n_out;
		logic [31:0]  acc_mult;
		logic [31:0]  bias_mult;
		bit           offset_out;
		fc_result_t   results_due [$];
		int           errors;

		function new();
			act_count  = 0;
			n_in       = DEF_IN_LEN;
			n_out      = DEF_OUT_LEN;
			acc_mult   = DEF_MULT;
			bias_mult  = DEF_MULT;
			offset_out = 0;
			errors     = 0;
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("mismatch: %s", msg);
		endtask

		function void set_register(reg_idx_t idx, logic [31:0] data);
			int unsigned len;
			case (idx)
			REG_IN_LEN: begin
				len = {23'd0, data[8:0]};
				if (len == 0)
					len = 1;
				else if (len > DEF_MAX_IN)
					len = DEF_MAX_IN;
				n_in      = len;
				act_count = 0;   // a new length restarts the vector
			end
			REG_OUT_LEN: begin
				len = {25'd0, data[6:0]};
				if (len == 0)
					len = 1;
				else if (len > DEF_MAX_OUT)
					len = DEF_MAX_OUT;
				n_out = len;
			end
			REG_ACC_MULT:     acc_mult = data;
			REG_BIAS_MULT:    bias_mult = data;
			REG_OUT_UNSIGNED: offset_out = data[0];
			default: ;
			endcase
		endfunction

		function logic [7:0] channel_byte(int n);
			longint dot;
			longint total;
			longint r;
			int     k;
			dot = 0;
			for (k = 0; k < n_in; k++)
				dot += (int'(act_mem[k]) - ZERO_POINT) * (int'(weight_mem[k][n]) - ZERO_POINT);
			total = dot * longint'({32'd0, acc_mult})
				+ longint'(int'(bias_mem[n]) - ZERO_POINT) * longint'({32'd0, bias_mult});
			r = (total + RND_HALF) >>> FRAC_BITS;   // floor, so ties go up
			if (r > SAT_HI)
				r = SAT_HI;
			if (r < SAT_LO)
				r = SAT_LO;
			if (offset_out)
				r += ZERO_POINT;
			return r[7:0];
		endfunction

		function void take_word(logic [1:0] fn, logic [7:0] row, logic [5:0] col,
				logic [7:0] val);
			fc_result_t r;
			int         n;
			case (fn)
			FUNC_WEIGHT: weight_mem[row][col] = val;
			FUNC_BIAS:   bias_mem[col] = val;
			FUNC_ACT: begin
				if (act_count >= n_in)
					act_count = 0;
				act_mem[act_count] = val;
				act_count++;
				if (act_count == n_in) begin
					act_count = 0;
					for (n = 0; n < n_out; n++) begin
						r.channel   = 6'(n);
						r.out_value = channel_byte(n);
						r.last      = (n == n_out - 1);
						results_due = {results_due, r};
					end
				end
			end
			default: ;
			endcase
		endfunction

		task match_output(logic [5:0] ch, logic [7:0] val, logic lst);
			fc_result_t want;
			if (results_due.size() == 0) begin
				report($sformatf("unexpected result ch %0d value %02h last %0d", ch, val, lst));
			end else begin
				want = results_due.pop_front();
				if (ch !== want.channel)
					report($sformatf("channel got %0d want %0d", ch, want.channel));
				if (val !== want.out_value)
					report($sformatf("ch %0d out_value got %02h want %02h",
						want.channel, val, want.out_value));
				if (lst !== want.last)
					report($sformatf("ch %0d last got %0d want %0d", want.channel, lst, want.last));
			end
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  func = FUNC_WEIGHT;
	logic [7:0]  row_index = 0;
	logic [5:0]  col_index = 0;
	logic [7:0]  value = 0;
	logic        result_strobe;
	logic [5:0]  channel;
	logic [7:0]  out_value;
	logic        last;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	linear_layer_mirror sb;
	int                 idle_pct = 0;
	int                 rand_sent = 0;
	int                 cycles = 0;

	quantized_linear_layer_top uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.func(func), .row_index(row_index), .col_index(col_index), .value(value),
		.result_strobe(result_strobe), .channel(channel), .out_value(out_value), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.match_output(channel, out_value, last);
	end

	// Present one word, hold it until taken, then maybe leave a gap.
	task automatic issue_word(logic [1:0] fn, logic [7:0] row, logic [5:0] col,
			logic [7:0] val);
		start     <= 1'b1;
		func      <= fn;
		row_index <= row;
		col_index <= col;
		value     <= val;
		do @(posedge clk); while (busy);
		sb.take_word(fn, row, col, val);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic read_check(reg_idx_t idx, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			sb.report($sformatf("reg %0d read %08h want %08h", idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Drain: all results in, then let the tail of the sequencer finish.
	task automatic settle();
		start <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic random_setting();
		logic [31:0] in_len;
		logic [31:0] out_len;
		logic [31:0] acc;
		logic [31:0] bmul;
		case ($urandom_range(9))
		0:       in_len = 1;
		1:       in_len = 0;
		default: in_len = $urandom_range(2, LOAD_ROWS);
		endcase
		case ($urandom_range(7))
		0:       out_len = 1;
		1:       out_len = 64;
		2:       out_len = 0;
		default: out_len = $urandom_range(2, LOAD_COLS);
		endcase
		// the wide channels only have weights in row zero
		if (out_len > LOAD_COLS)
			in_len = 1;
		case ($urandom_range(7))
		0:       acc = 32'h0;
		1:       acc = 32'hFFFF_FFFF;
		2:       acc = $urandom();
		default: acc = $urandom_range(1 << 12, 1 << 20);
		endcase
		case ($urandom_range(5))
		0:       bmul = 32'h0;
		1:       bmul = 32'hFFFF_FFFF;
		default: bmul = $urandom_range(0, 1 << 25);
		endcase
		// junk in the unused upper bits must be dropped
		write_reg(REG_IN_LEN, {23'($urandom_range(0, 8388607)), in_len[8:0]});
		write_reg(REG_OUT_LEN, {25'($urandom_range(0, 33554431)), out_len[6:0]});
		write_reg(REG_ACC_MULT, acc);
		write_reg(REG_BIAS_MULT, bmul);
		write_reg(REG_OUT_UNSIGNED, {1'($urandom_range(0, 1)), 30'd0,
			1'($urandom_range(0, 1))});
	endtask

	initial begin
		int r;
		int c;
		int i;
		int burst;
		int pick;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register values after reset.
		read_check(REG_IN_LEN, 32'(DEF_IN_LEN));
		read_check(REG_OUT_LEN, 32'(DEF_OUT_LEN));
		read_check(REG_ACC_MULT, DEF_MULT);
		read_check(REG_BIAS_MULT, DEF_MULT);
		read_check(REG_OUT_UNSIGNED, 32'd0);

		// Load the store region that the vectors below read; row zero spans all channels.
		idle_pct = 29;
		for (r = 0; r < LOAD_ROWS; r++)
			for (c = 0; c < LOAD_COLS; c++)
				issue_word(FUNC_WEIGHT, r[7:0], c[5:0], 8'($urandom_range(255)));
		for (c = LOAD_COLS; c < DEF_MAX_OUT; c++)
			issue_word(FUNC_WEIGHT, 8'd0, c[5:0], 8'($urandom_range(255)));
		for (c = 0; c < DEF_MAX_OUT; c++)
			issue_word(FUNC_BIAS, 8'd0, c[5:0], 8'($urandom_range(255)));

		// Byte extremes, both saturation limits, the unused code.
		write_reg(REG_IN_LEN, 2);
		write_reg(REG_OUT_LEN, 3);
		write_reg(REG_ACC_MULT, DEF_MULT);
		write_reg(REG_BIAS_MULT, DEF_MULT);
		write_reg(REG_OUT_UNSIGNED, 0);
		issue_word(FUNC_WEIGHT, 8'd0, 6'd0, 8'd255);
		issue_word(FUNC_WEIGHT, 8'd1, 6'd0, 8'd255);
		issue_word(FUNC_WEIGHT, 8'd0, 6'd1, 8'd0);
		issue_word(FUNC_WEIGHT, 8'd1, 6'd1, 8'd255);
		issue_word(FUNC_WEIGHT, 8'd0, 6'd2, 8'd128);
		issue_word(FUNC_WEIGHT, 8'd1, 6'd2, 8'd0);
		issue_word(FUNC_BIAS, 8'd0, 6'd0, 8'd255);
		issue_word(FUNC_BIAS, 8'd0, 6'd1, 8'd0);
		issue_word(FUNC_BIAS, 8'd0, 6'd2, 8'd128);
		issue_word(FUNC_UNUSED, 8'd255, 6'd63, 8'd255);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd255);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd255);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd0);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd255);
		settle();

		// Exact halves: +0.5 rounds up, -0.5 rounds to zero; offset output.
		write_reg(REG_IN_LEN, 1);
		write_reg(REG_OUT_LEN, 2);
		write_reg(REG_ACC_MULT, 32'h0080_0000);
		write_reg(REG_BIAS_MULT, 32'h0);
		write_reg(REG_OUT_UNSIGNED, 1);
		issue_word(FUNC_WEIGHT, 8'd0, 6'd0, 8'd129);
		issue_word(FUNC_WEIGHT, 8'd0, 6'd1, 8'd127);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd129);
		settle();

		// Length rewritten mid-vector restarts it; zero lengths clamp to one.
		write_reg(REG_IN_LEN, 3);
		write_reg(REG_OUT_LEN, 0);
		write_reg(REG_ACC_MULT, DEF_MULT);
		write_reg(REG_OUT_UNSIGNED, 0);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd0);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd255);
		settle();
		write_reg(REG_IN_LEN, 4);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd1);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd254);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd128);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd77);
		settle();
		write_reg(REG_IN_LEN, 0);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'd200);
		settle();

		// Oversized lengths clamp to the store size; one vector over every channel.
		write_reg(REG_IN_LEN, 300);
		read_check(REG_IN_LEN, 32'(DEF_MAX_IN));
		write_reg(REG_IN_LEN, 1);
		write_reg(REG_OUT_LEN, 100);
		read_check(REG_OUT_LEN, 32'(DEF_MAX_OUT));
		write_reg(REG_ACC_MULT, $urandom_range(8000, 30000));
		write_reg(REG_BIAS_MULT, 32'h0010_0000);
		write_reg(REG_OUT_UNSIGNED, 1);
		issue_word(FUNC_ACT, 8'd0, 6'd0, 8'($urandom_range(255)));
		settle();

		// Random part: mostly activation streams, some store updates and noise.
		while (rand_sent < RAND_ITEMS) begin
			settle();
			random_setting();
			burst = $urandom_range(20, 60);
			for (i = 0; i < burst; i++) begin
				if (rand_sent < RAND_ITEMS / 3)
					idle_pct = 29;
				else if (rand_sent < 2 * RAND_ITEMS / 3)
					idle_pct = 73;
				else
					idle_pct = 0;
				pick = $urandom_range(99);
				if (pick < 75) begin
					issue_word(FUNC_ACT, 8'($urandom_range(255)), 6'($urandom_range(63)),
						8'($urandom_range(255)));
					rand_sent++;
				end else if (pick < 87) begin
					issue_word(FUNC_WEIGHT, 8'($urandom_range(255)), 6'($urandom_range(63)),
						8'($urandom_range(255)));
					rand_sent++;
				end else if (pick < 95) begin
					issue_word(FUNC_BIAS, 8'($urandom_range(255)), 6'($urandom_range(63)),
						8'($urandom_range(255)));
					rand_sent++;
				end else begin
					issue_word(FUNC_UNUSED, 8'($urandom_range(255)), 6'($urandom_range(63)),
						8'($urandom_range(255)));
				end
				// sender holds off now and then until the layer has caught up
				if ($urandom_range(49) == 0)
					settle();
			end
		end

		settle();
		repeat (64) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d results never arrived", sb.outstanding()));
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
